// ===== hw/rtl/kmmst_pkg.sv =====
// Package for the keyed min/max score table: opcodes and widths of the item fields.
// No dependencies; all other files import it.
`timescale 1ns / 1ps
package kmmst_pkg;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned IdW    = 17;
  localparam int unsigned CountW = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_SPARE  = 2'd3
  } opcode_e;
endpackage

// ===== hw/rtl/keyed_min_max_score_table.sv =====
// Top level of the keyed min/max score table.
// Depends on kmmst_pkg and kmmst_ram.
//
// Usage: one input item is one operation (insert/update, erase, lookup) on
// one node id; each item produces exactly one result item.
// Slots live in a synchronous RAM (key and score per slot); a valid bit per
// slot is kept in flip-flops, cleared at once by reset.
// Per item a sequencer sweeps all slots, one per cycle, through the RAM read
// port: the sweep finds the node's slot and a free slot. Then the APPLY state
// applies the write, and a second sweep over all slots tracks the greatest
// and smallest (score, id). The result is registered in S_OUT, and no new
// item is accepted until the previous one has left S_OUT, as the single RAM
// port walks the table twice per item.
// The result sits in an output register; the next item is taken while it
// waits, but its own result is held until the previous one is taken, and
// s_axis_tready stays low meanwhile.
// Reset empties the table (count zero, no valid slots); no clearing pass.
// A stalled receiver simply holds m_axis_tdata/tvalid steady.
`timescale 1ns / 1ps
module keyed_min_max_score_table
  import kmmst_pkg::*;
#(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned NODE_ID_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: opcode[1:0], node_id[17:2], new_score[49:18], zero pad to 56
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: was_present[0], prior_score[32:1], best_id[49:33],
  // worst_id[66:50], entry_count[73:67], status[74], zero pad to 80
  output logic [79:0] m_axis_tdata
);
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned EW   = 16 + ScoreW;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_APPLY, S_SCAN, S_OUT
  } state_e;

  state_e state_q;
  logic [AW:0] idx_q;                 // sweep counter, one wider for the end
  logic [AW-1:0] rd_idx_q;            // slot whose data arrives this cycle
  logic          rd_v_q;
  opcode_e       op_q;
  logic [15:0]   key_q;
  logic [ScoreW-1:0] nscore_q;
  logic [CAPACITY-1:0] valid_q;
  logic [CntW-1:0] count_q;
  logic          found_q, free_ok_q;
  logic [AW-1:0] found_q_idx, free_q;
  logic [ScoreW-1:0] prior_q;
  logic          have_q;
  logic [15:0]   bkey_q, wkey_q;
  logic [ScoreW-1:0] bsc_q, wsc_q;
  logic          status_q;
  logic          obusy_q;
  logic [79:0]   odata_q;

  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;
  logic [15:0]   r_key;
  logic signed [ScoreW-1:0] r_sc;

  kmmst_ram #(.Width(EW), .Depth(CAPACITY)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  assign r_key = rdata[15:0];
  assign r_sc  = rdata[EW-1:16];

  // Address the RAM: write slot in APPLY, sweep counter otherwise.
  always_comb begin
    we    = 1'b0;
    addr  = idx_q[AW-1:0];
    wdata = {nscore_q, key_q};
    if (state_q == S_APPLY) begin
      addr = found_q ? found_q_idx : free_q;
      we   = (op_q == OP_INSERT) && (found_q || free_ok_q);
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = obusy_q;
  assign m_axis_tdata  = odata_q;

  logic [15:0] in_key;
  assign in_key = s_axis_tdata[17:2] & 16'((33'd1 << NODE_ID_BITS) - 33'd1);

  logic hit_best, hit_worst;
  assign hit_best = !have_q || (r_sc > $signed(bsc_q))
                    || (r_sc == $signed(bsc_q) && r_key > bkey_q);
  assign hit_worst = !have_q || (r_sc < $signed(wsc_q))
                     || (r_sc == $signed(wsc_q) && r_key < wkey_q);

  // Sequence one item: find, apply, scan, deliver.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      count_q  <= '0;
      obusy_q  <= 1'b0;
      rd_v_q   <= 1'b0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      free_ok_q <= 1'b0;
      have_q   <= 1'b0;
    end else begin
      // Raise the output valid on a new result, drop it once taken.
      if (state_q == S_OUT && (!obusy_q || m_axis_tready)) begin
        obusy_q <= 1'b1;
      end else if (m_axis_tready) begin
        obusy_q <= 1'b0;
      end
      // Mark a slot read issued by either sweep.
      rd_v_q   <= (state_q == S_FIND || state_q == S_SCAN)
                  && (idx_q < (AW+1)'(CAPACITY));
      rd_idx_q <= idx_q[AW-1:0];
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          op_q      <= opcode_e'(s_axis_tdata[1:0]);
          key_q     <= in_key;
          nscore_q  <= s_axis_tdata[49:18];
          idx_q     <= '0;
          found_q   <= 1'b0;
          free_ok_q <= 1'b0;
          prior_q   <= '0;
          status_q  <= 1'b0;
          state_q   <= S_FIND;
        end
        S_FIND: begin
          if (idx_q < (AW+1)'(CAPACITY)) begin
            idx_q  <= idx_q + 1'b1;
          end else if (!rd_v_q) begin
            state_q <= S_APPLY;
          end
          // Check the slot whose data arrived.
          if (rd_v_q) begin
            if (valid_q[rd_idx_q] && r_key == key_q && !found_q) begin
              found_q     <= 1'b1;
              found_q_idx <= rd_idx_q;
              prior_q     <= r_sc;
            end
          end
          if (idx_q < (AW+1)'(CAPACITY) && !valid_q[idx_q[AW-1:0]] && !free_ok_q) begin
            free_ok_q <= 1'b1;
            free_q    <= idx_q[AW-1:0];
          end
        end
        S_APPLY: begin
          if (op_q == OP_INSERT) begin
            if (!found_q) begin
              if (free_ok_q) begin
                valid_q[free_q] <= 1'b1;
                count_q <= count_q + 1'b1;
              end else begin
                status_q <= 1'b1;
              end
            end
          end else if (op_q == OP_ERASE && found_q) begin
            valid_q[found_q_idx] <= 1'b0;
            count_q <= count_q - 1'b1;
          end
          idx_q   <= '0;
          have_q  <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (idx_q < (AW+1)'(CAPACITY)) begin
            idx_q  <= idx_q + 1'b1;
          end else if (!rd_v_q) begin
            state_q <= S_OUT;
          end
          // Track extremes over valid slots.
          if (rd_v_q && valid_q[rd_idx_q]) begin
            have_q <= 1'b1;
            if (hit_best) begin
              bkey_q <= r_key;
              bsc_q  <= r_sc;
            end
            if (hit_worst) begin
              wkey_q <= r_key;
              wsc_q  <= r_sc;
            end
          end
        end
        S_OUT: if (!obusy_q || m_axis_tready) begin
          odata_q <= {5'd0, status_q, CountW'(count_q),
                      have_q ? {1'b0, wkey_q} : {IdW{1'b1}},
                      have_q ? {1'b0, bkey_q} : {IdW{1'b1}},
                      prior_q, found_q};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Count never exceeds capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY)) else $error("count above capacity");
  // Empty table reports no best id.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[73:67] == '0) |-> m_axis_tdata[49:33] == '1)
    else $error("empty table with best id");
  // Rejection only on insert of a new node into a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && status_q) |-> (op_q == OP_INSERT && !found_q && !free_ok_q))
    else $error("status without a full-table insert");
  // Output held while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output changed while stalled");
endmodule

// ===== hw/rtl/kmmst_ram.sv =====
// Generic single-port RAM with a registered read port.
// Depends on kmmst_pkg only through the common import style.
`timescale 1ns / 1ps
module kmmst_ram
  import kmmst_pkg::*;
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write at addr, register the read of the same addr.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
